// File: rtl/core/lpr_pkg.sv
package lpr_pkg;

    // Field widths
    localparam int Z_W       = 32;
    localparam int ALPHA_W   = 4;
    localparam int VAL_W     = 64;
    localparam int DEG_W     = 4;
    localparam int NDEG_W    = 5;
    localparam int FRAC_BITS = 24;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_NUM_DEGREES = '0;
    localparam logic [NDEG_W-1:0]  NUM_DEGREES_RST = NDEG_W'(16);

    // Run length limits
    localparam int RUN_MIN = 2;
    localparam int RUN_CAP = 16;

    // Reciprocal table and coefficient datapath
    localparam int RECIP_W = 32;
    localparam int T_W     = Z_W + 1;
    localparam int QPROD_W = T_W + RECIP_W + 1;
    localparam int COEF_W  = 33;
    localparam logic [DEG_W-1:0] K_FIRST_REC = DEG_W'(2);

    // Multiply-accumulate chain
    localparam int NUM_CELLS  = 4;
    localparam int CNT_W      = $clog2(NUM_CELLS);
    localparam int LIMB_SHIFT = VAL_W / 2;
    localparam int LIMB_W     = LIMB_SHIFT + 1;
    localparam int PROD_W     = COEF_W + LIMB_W;
    localparam int ACC_W      = PROD_W + LIMB_SHIFT;
    localparam int RND_W      = ACC_W - FRAC_BITS;

    // Fixed-point constants
    localparam logic [VAL_W-1:0] ONE_Q   = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT0,
        ST_EMIT1,
        ST_LOAD,
        ST_ACC,
        ST_ROUND
    } state_t;

    typedef struct packed {
        logic ld;
        logic negate;
        logic high;
    } cell_ctrl_t;

    typedef struct packed {
        logic             load;
        logic [DEG_W-1:0] kc;
    } coef_ctrl_t;

    // floor((2^32 + floor(k/2)) / k), unsigned Q0.32
    function automatic logic [RECIP_W-1:0] recip_lookup(input logic [DEG_W-1:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            DEG_W'(2):  r = 32'h8000_0000;
            DEG_W'(3):  r = 32'h5555_5555;
            DEG_W'(4):  r = 32'h4000_0000;
            DEG_W'(5):  r = 32'h3333_3333;
            DEG_W'(6):  r = 32'h2AAA_AAAB;
            DEG_W'(7):  r = 32'h2492_4925;
            DEG_W'(8):  r = 32'h2000_0000;
            DEG_W'(9):  r = 32'h1C71_C71C;
            DEG_W'(10): r = 32'h1999_999A;
            DEG_W'(11): r = 32'h1745_D174;
            DEG_W'(12): r = 32'h1555_5555;
            DEG_W'(13): r = 32'h13B1_3B14;
            DEG_W'(14): r = 32'h1249_2492;
            DEG_W'(15): r = 32'h1111_1111;
            default:    r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/lpr_coef_unit.sv
module lpr_coef_unit (
    input  logic                              aclk,
    input  lpr_pkg::coef_ctrl_t               ctrl,
    input  logic signed [lpr_pkg::Z_W-1:0]    z_value,
    input  logic [lpr_pkg::ALPHA_W-1:0]       alpha_order,
    output logic signed [lpr_pkg::COEF_W-1:0] c1,
    output logic signed [lpr_pkg::COEF_W-1:0] c2
);
    import lpr_pkg::*;

    localparam longint RND_Q = longint'(1) << (RECIP_W - 1);
    localparam longint TWO_Q = longint'(2) << FRAC_BITS;

    logic signed [T_W-1:0]     am1;
    logic signed [T_W-1:0]     t1_next;
    logic signed [T_W-1:0]     t1_reg;
    logic signed [T_W-1:0]     t2_reg;
    logic signed [RECIP_W:0]   recip;
    logic signed [QPROD_W-1:0] p1_reg;
    logic signed [QPROD_W-1:0] p2_reg;
    logic signed [QPROD_W-1:0] p1_rnd;
    logic signed [QPROD_W-1:0] p2_rnd;
    logic signed [COEF_W-1:0]  c1_reg;
    logic signed [COEF_W-1:0]  c2_reg;

    // (alpha - 1) and (alpha - 1 - z), both in Q.FRAC_BITS
    assign am1     = (T_W'(alpha_order) - T_W'(1)) <<< FRAC_BITS;
    assign t1_next = am1 - {{(T_W-Z_W){z_value[Z_W-1]}}, z_value};
    assign recip   = {1'b0, recip_lookup(ctrl.kc)};

    // Round half up, drop the reciprocal's fraction bits
    assign p1_rnd = p1_reg + QPROD_W'(RND_Q);
    assign p2_rnd = p2_reg + QPROD_W'(RND_Q);

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            t1_reg <= t1_next;
            t2_reg <= am1;
        end
        p1_reg <= t1_reg * recip;
        p2_reg <= t2_reg * recip;
        c1_reg <= COEF_W'(p1_rnd >>> RECIP_W) + COEF_W'(TWO_Q);
        c2_reg <= COEF_W'(p2_rnd >>> RECIP_W) + COEF_W'(ONE_Q);
    end

    assign c1 = c1_reg;
    assign c2 = c2_reg;

endmodule

// File: rtl/core/lpr_mac_cell.sv
module lpr_mac_cell (
    input  logic                              aclk,
    input  lpr_pkg::cell_ctrl_t               ctrl,
    input  logic signed [lpr_pkg::COEF_W-1:0] coef,
    input  logic signed [lpr_pkg::LIMB_W-1:0] limb,
    input  logic signed [lpr_pkg::ACC_W-1:0]  acc_in,
    output logic signed [lpr_pkg::ACC_W-1:0]  acc_out
);
    import lpr_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  acc_reg;

    // Upper limb products carry a weight of 2^32
    assign term = ctrl.high ? {prod_reg, {LIMB_SHIFT{1'b0}}}
                            : {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge aclk) begin
        if (ctrl.ld) begin
            prod_reg <= coef * limb;
        end
        acc_reg <= ctrl.negate ? acc_in - term : acc_in + term;
    end

    assign acc_out = acc_reg;

endmodule

// File: rtl/core/laguerre_poly_recurrence.sv
// Generalized Laguerre evaluator: L_k^alpha(z) for k = 0 .. n-1 per point.
//
// Input channel (s_*): one transaction carries a point z (signed Q8.24) and
// an order alpha. Result channel (m_*): one transaction per degree, value in
// signed Q40.24, the degree, a last-of-run flag and a sticky clip flag.
// n comes from the num_degrees register (APB, byte address 0), clamped to
// 2..16 and sampled when the point is taken.
//
// The degree 0 result is registered from the first emit state, entered on
// the accepting edge, and degree 1 from the second emit state after it when
// the receiver keeps up. Each further degree passes through a load of four
// partial products into the multiply-accumulate chain, accumulation while
// the sum walks down the four cells, and a final round-and-saturate step.
// The reciprocal and coefficient unit for the next degree runs under the
// chain and does not lengthen a degree.
//
// Reset (aresetn low at a clock edge) drops any run in progress, empties
// the result register and sets num_degrees back to 16. When the receiver
// stalls, the run holds at the next result until the register drains; a
// new point is taken as soon as the last result of a run is registered.
module laguerre_poly_recurrence (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [lpr_pkg::Z_W-1:0]    s_z_value,
    input  logic [lpr_pkg::ALPHA_W-1:0]       s_alpha_order,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [lpr_pkg::VAL_W-1:0]  m_poly_value,
    output logic [lpr_pkg::DEG_W-1:0]         m_degree_index,
    output logic                              m_last_of_run,
    output logic                              m_saturated,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpr_pkg::PADDR_W-1:0]       paddr,
    input  logic [lpr_pkg::PDATA_W-1:0]       pwdata,
    output logic [lpr_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import lpr_pkg::*;

    localparam longint HALF_LSB = longint'(1) << (FRAC_BITS - 1);

    // Control state
    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DEG_W-1:0]   k_reg;
    logic [NDEG_W-1:0]  num_degrees_reg;
    logic               m_valid_reg;

    // Run state
    logic [NDEG_W-1:0]  n_reg;
    logic [NDEG_W-1:0]  n_next;
    logic               clip_reg;
    logic signed [VAL_W-1:0] prev1_reg;
    logic signed [VAL_W-1:0] prev2_reg;
    logic signed [VAL_W-1:0] prev1_init;

    // Result register
    logic signed [VAL_W-1:0] m_poly_value_reg;
    logic [DEG_W-1:0]        m_degree_index_reg;
    logic                    m_last_of_run_reg;
    logic                    m_saturated_reg;

    // Handshake and sequencing
    logic               out_free;
    logic               take_item;
    logic               emit;
    logic               is_last;
    logic               cnt_last;
    logic               cell_ld;
    logic [VAL_W-1:0]   emit_val;
    coef_ctrl_t         coef_ctrl;
    logic               cfg_write;
    logic               cfg_hit;

    // Arithmetic
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
    logic signed [LIMB_W-1:0] pair_hi [2];
    logic signed [LIMB_W-1:0] pair_lo [2];
    logic signed [COEF_W-1:0] pair_coef [2];
    logic signed [ACC_W-1:0]  chain_acc [NUM_CELLS+1];
    logic signed [ACC_W-1:0]  rnd_sum;
    logic [RND_W-1:0]         rnd_val;
    logic                     fits;
    logic                     clip_now;
    logic [VAL_W-1:0]         sat_val;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[PADDR_W-1:2] == REG_NUM_DEGREES);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
    assign prdata    = cfg_hit ? PDATA_W'(num_degrees_reg) : '0;

    // Clamp the run length to 2..16
    always_comb begin
        n_next = num_degrees_reg;
        if (num_degrees_reg < NDEG_W'(RUN_MIN)) begin
            n_next = NDEG_W'(RUN_MIN);
        end else if (num_degrees_reg > NDEG_W'(RUN_CAP)) begin
            n_next = NDEG_W'(RUN_CAP);
        end
    end

    // L1 = (alpha + 1) - z
    assign prev1_init = ((VAL_W'(s_alpha_order) + VAL_W'(1)) << FRAC_BITS)
                        - {{(VAL_W-Z_W){s_z_value[Z_W-1]}}, s_z_value};

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign is_last  = (k_reg == DEG_W'(n_reg - NDEG_W'(1)));
    assign cnt_last = (cnt_reg == CNT_W'(NUM_CELLS - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EMIT0;
                end
            end
            ST_EMIT0: begin
                if (out_free) begin
                    state_next = ST_EMIT1;
                end
            end
            ST_EMIT1: begin
                if (out_free) begin
                    state_next = is_last ? ST_IDLE : ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (cnt_last) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (out_free) begin
                    state_next = is_last ? ST_IDLE : ST_LOAD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        emit           = 1'b0;
        emit_val       = sat_val;
        cell_ld        = 1'b0;
        coef_ctrl.load = 1'b0;
        coef_ctrl.kc   = k_reg + DEG_W'(1);
        case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                coef_ctrl.load = s_valid;
                coef_ctrl.kc   = K_FIRST_REC;
            end
            ST_EMIT0: begin
                emit         = out_free;
                emit_val     = ONE_Q;
                coef_ctrl.kc = K_FIRST_REC;
            end
            ST_EMIT1: begin
                emit         = out_free;
                emit_val     = prev1_reg;
                coef_ctrl.kc = K_FIRST_REC;
            end
            ST_LOAD: begin
                cell_ld = 1'b1;
            end
            ST_ACC: begin
                cell_ld = 1'b0;
            end
            ST_ROUND: begin
                emit     = out_free;
                emit_val = sat_val;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign take_item = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            k_reg           <= '0;
            num_degrees_reg <= NUM_DEGREES_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_write) begin
                num_degrees_reg <= pwdata[NDEG_W-1:0];
            end
            // Count the cells the partial sum has passed
            if (state_reg == ST_LOAD) begin
                cnt_reg <= '0;
            end else if (state_reg == ST_ACC) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (take_item) begin
                k_reg <= '0;
            end else if (emit) begin
                k_reg <= k_reg + DEG_W'(1);
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Run state and result register
    always_ff @(posedge aclk) begin
        if (take_item) begin
            n_reg     <= n_next;
            clip_reg  <= 1'b0;
            prev2_reg <= ONE_Q;
            prev1_reg <= prev1_init;
        end else if (emit && state_reg == ST_ROUND) begin
            clip_reg  <= clip_reg | clip_now;
            prev2_reg <= prev1_reg;
            prev1_reg <= sat_val;
        end
        if (emit) begin
            m_poly_value_reg   <= emit_val;
            m_degree_index_reg <= k_reg;
            m_last_of_run_reg  <= is_last;
            m_saturated_reg    <= clip_reg | (clip_now && state_reg == ST_ROUND);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_poly_value   = m_poly_value_reg;
    assign m_degree_index = m_degree_index_reg;
    assign m_last_of_run  = m_last_of_run_reg;
    assign m_saturated    = m_saturated_reg;

    // ---------------------------------------------------------------
    // Coefficients c1 = 2 + (alpha-1-z)/k, c2 = 1 + (alpha-1)/k
    // ---------------------------------------------------------------
    lpr_coef_unit u_coef (
        .aclk        (aclk),
        .ctrl        (coef_ctrl),
        .z_value     (s_z_value),
        .alpha_order (s_alpha_order),
        .c1          (c1),
        .c2          (c2)
    );

    // ---------------------------------------------------------------
    // Multiply-accumulate chain: c1*L1 - c2*L2 split into 32-bit limbs.
    // Pair 0 is c1 against L_{k-1}, pair 1 is c2 against L_{k-2}.
    // ---------------------------------------------------------------
    assign pair_coef[0] = c1;
    assign pair_coef[1] = c2;
    assign pair_hi[0]   = {prev1_reg[VAL_W-1], prev1_reg[VAL_W-1:LIMB_SHIFT]};
    assign pair_lo[0]   = {1'b0, prev1_reg[LIMB_SHIFT-1:0]};
    assign pair_hi[1]   = {prev2_reg[VAL_W-1], prev2_reg[VAL_W-1:LIMB_SHIFT]};
    assign pair_lo[1]   = {1'b0, prev2_reg[LIMB_SHIFT-1:0]};

    assign chain_acc[0] = '0;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        localparam int  PAIR      = i / 2;
        localparam bit  CELL_HIGH = ((i % 2) == 0);
        localparam bit  CELL_NEG  = (PAIR == 1);
        cell_ctrl_t               ctrl;
        logic signed [LIMB_W-1:0] limb;

        assign ctrl.ld     = cell_ld;
        assign ctrl.negate = CELL_NEG;
        assign ctrl.high   = CELL_HIGH;
        assign limb        = CELL_HIGH ? pair_hi[PAIR] : pair_lo[PAIR];

        lpr_mac_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .coef    (pair_coef[PAIR]),
            .limb    (limb),
            .acc_in  (chain_acc[i]),
            .acc_out (chain_acc[i+1])
        );
    end

    // Round half up, drop the fraction bits, clip to 64 bits
    assign rnd_sum  = chain_acc[NUM_CELLS] + ACC_W'(HALF_LSB);
    assign rnd_val  = rnd_sum[ACC_W-1:FRAC_BITS];
    assign fits     = (rnd_val[RND_W-1:VAL_W-1] == '0)
                   || (rnd_val[RND_W-1:VAL_W-1] == '1);
    assign clip_now = !fits;
    assign sat_val  = fits ? rnd_val[VAL_W-1:0]
                           : (rnd_val[RND_W-1] ? VAL_MIN : VAL_MAX);

`ifndef SYNTH
    a_accept_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_EMIT0)
        else $error("accepted point did not start a run");

    a_load_enters_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD |=> state_reg == ST_ACC && cnt_reg == '0)
        else $error("product load not followed by chain accumulation");

    a_seed_unclipped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_degree_index == DEG_W'(0) || m_degree_index == DEG_W'(1))
        |-> !m_saturated)
        else $error("seed degree flagged as clipped");
`endif

endmodule

// File: bench/tb_top.sv
`default_nettype none

// Self-checking bench for the generalized Laguerre evaluator.
// Every accepted point is run through a bit-exact predictor of the fixed-point
// recurrence. The whole run of degree values goes into a queue, and the
// monitor checks each result transaction against the head of that queue.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    localparam int RANDOM_ITEMS   = 211;
    localparam int CALM_ITEMS     = 40;    // final stretch runs with no idling
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
    localparam int TAIL_CYCLES    = 100;   // covers one full run at the largest degree count

    // Register map: index i at byte address 4*i; only index 0 exists.
    localparam logic [PADDR_W-1:0] ADDR_NUM_DEGREES = {REG_NUM_DEGREES, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED    = {~REG_NUM_DEGREES, 2'b00};

    typedef struct {
        logic [VAL_W-1:0] value;
        logic [DEG_W-1:0] degree;
        logic             last;
        logic             clipped;
    } term_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [Z_W-1:0]      s_z_value;
    logic [ALPHA_W-1:0]         s_alpha_order;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [VAL_W-1:0]    m_poly_value;
    logic [DEG_W-1:0]           m_degree_index;
    logic                       m_last_of_run;
    logic                       m_saturated;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    term_t                      expected_terms[$];
    term_t                      head_term;
    logic [NDEG_W-1:0]          ndeg_cfg;      // shadow of the num_degrees register
    bit                         idle_on;       // random idling enabled on both sides
    int                         stall_left;
    int                         quiet_cycles;
    int                         err_count;

    laguerre_poly_recurrence uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_z_value      (s_z_value),
        .s_alpha_order  (s_alpha_order),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_poly_value   (m_poly_value),
        .m_degree_index (m_degree_index),
        .m_last_of_run  (m_last_of_run),
        .m_saturated    (m_saturated),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Divide a Q.F value by k: multiply by the Q0.32 reciprocal, round half
    // up and drop the 32 reciprocal fraction bits.
    function automatic logic signed [VAL_W-1:0] quot_by_deg(input logic signed [VAL_W-1:0] t,
                                                           input int k);
        logic [63:0]          recip;
        logic signed [127:0]  prod;
        recip = ((64'd1 << RECIP_W) + 64'(k / 2)) / 64'(k);
        prod  = t;
        prod  = prod * $signed({64'd0, recip});
        prod  = prod + (128'sd1 <<< (RECIP_W - 1));
        prod  = prod >>> RECIP_W;
        return prod[VAL_W-1:0];
    endfunction

    // Compute the full run of L_k^alpha(z) for the current degree count and
    // queue one expected result per degree.
    function automatic void laguerre_run(input logic signed [Z_W-1:0] z,
                                         input logic [ALPHA_W-1:0] alpha);
        int                       n;
        logic signed [VAL_W-1:0]  zx;
        logic signed [VAL_W-1:0]  l_prev2;
        logic signed [VAL_W-1:0]  l_prev1;
        logic signed [VAL_W-1:0]  am1;
        logic signed [VAL_W-1:0]  c1;
        logic signed [VAL_W-1:0]  c2;
        logic signed [VAL_W-1:0]  v;
        logic signed [127:0]      wa;
        logic signed [127:0]      wb;
        logic signed [127:0]      acc;
        logic                     clip;
        term_t                    t;
        n = ndeg_cfg;
        if (n < RUN_MIN) n = RUN_MIN;
        if (n > RUN_CAP) n = RUN_CAP;
        zx      = z;
        l_prev2 = ONE_Q;
        l_prev1 = ((64'(alpha) + 64'd1) << FRAC_BITS) - zx;
        am1     = (64'(alpha) - 64'd1) << FRAC_BITS;
        clip    = 1'b0;
        for (int k = 0; k < n; k++) begin
            if (k == 0) begin
                v = l_prev2;
            end else if (k == 1) begin
                v = l_prev1;
            end else begin
                c1  = 2 * ONE_Q + quot_by_deg(am1 - zx, k);
                c2  = ONE_Q + quot_by_deg(am1, k);
                wa  = c1;
                wb  = l_prev1;
                acc = wa * wb;
                wa  = c2;
                wb  = l_prev2;
                acc = acc - wa * wb;
                acc = acc + (128'sd1 <<< (FRAC_BITS - 1));
                acc = acc >>> FRAC_BITS;
                if (acc[127:64] == {64{acc[63]}}) begin
                    v = acc[63:0];
                end else begin
                    clip = 1'b1;
                    v = acc[127] ? VAL_MIN : VAL_MAX;
                end
                l_prev2 = l_prev1;
                l_prev1 = v;
            end
            t.value   = v;
            t.degree  = DEG_W'(k);
            t.last    = (k == n - 1);
            t.clipped = clip;
            expected_terms.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one point; optionally idle first. Return at the falling edge
    // after acceptance with valid still high, so back-to-back points keep
    // valid asserted without a glitch.
    task automatic send_point(input logic signed [Z_W-1:0] z, input logic [ALPHA_W-1:0] alpha);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_z_value     = z;
        s_alpha_order = alpha;
        do @(posedge aclk); while (!s_ready);
        laguerre_run(z, alpha);
        @(negedge aclk);
    endtask

    // Two-phase APB write; keep the shadow register in step.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr[PADDR_W-1:2] == REG_NUM_DEGREES)
            ndeg_cfg = data[NDEG_W-1:0];
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drop valid and wait until every queued result has come back.
    task automatic wait_drained;
        s_valid = 1'b0;
        while (expected_terms.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic signed [Z_W-1:0] gen_point;
        logic signed [Z_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 4))
            0: r = r >>> $urandom_range(4, 28);       // small magnitude, either sign
            1: r = {r[31:24], 24'd0};                 // whole numbers
            2: r = $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                        : 32'sh8000_0000 + $urandom_range(0, 3);
            default: ;                                // full range
        endcase
        return r;
    endfunction

    function automatic logic [PDATA_W-1:0] gen_degree_word;
        logic [PDATA_W-1:0] w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0: ;                                      // any 5-bit count, clamps included
            1: w[NDEG_W-1:0] = NDEG_W'(RUN_CAP);
            2: w[NDEG_W-1:0] = NDEG_W'(RUN_MIN);
            default: w[NDEG_W-1:0] = NDEG_W'($urandom_range(RUN_MIN, RUN_CAP));
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, monitor, watchdog
    // ------------------------------------------------------------------

    // Stall the receiver in random bursts while idling is on.
    always @(negedge aclk) begin
        if (!idle_on)
            stall_left = 0;
        if (!aresetn) begin
            m_ready = 1'b0;
        end else if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready = 1'b0;
            stall_left = $urandom_range(0, 10);
        end else begin
            m_ready = 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_terms.size() == 0) begin
                $display("%0t: unexpected result, degree %0d value %h", $time,
                         m_degree_index, m_poly_value);
                err_count++;
            end else begin
                head_term = expected_terms.pop_front();
                if (m_poly_value !== head_term.value) begin
                    $display("%0t: poly_value expected %h, got %h", $time,
                             head_term.value, m_poly_value);
                    err_count++;
                end
                if (m_degree_index !== head_term.degree) begin
                    $display("%0t: degree_index expected %0d, got %0d", $time,
                             head_term.degree, m_degree_index);
                    err_count++;
                end
                if (m_last_of_run !== head_term.last) begin
                    $display("%0t: last_of_run expected %b, got %b", $time,
                             head_term.last, m_last_of_run);
                    err_count++;
                end
                if (m_saturated !== head_term.clipped) begin
                    $display("%0t: saturated expected %b, got %b", $time,
                             head_term.clipped, m_saturated);
                    err_count++;
                end
            end
        end
    end

    // Abort if nothing moves on any port for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes at the reset degree count of 16; the large negative
    // points with high order drive the run into saturation.
    task automatic test_extremes;
        idle_on = 1'b1;
        send_point(32'sd0, ALPHA_W'(0));
        send_point(32'sh7FFF_FFFF, ALPHA_W'(15));
        send_point(32'sh8000_0000, ALPHA_W'(15));
        send_point(32'sh8000_0000, ALPHA_W'(0));
        send_point(32'sh7FFF_FFFF, ALPHA_W'(0));
        send_point(32'sh0100_0000, ALPHA_W'(0));      // z = 1.0: L1 is exactly zero
        send_point(-32'sd1, ALPHA_W'(1));
        send_point(32'sd1, ALPHA_W'(10));
        send_point(32'shC000_0000, ALPHA_W'(7));
        send_point(32'sh0280_0000, ALPHA_W'(5));
        wait_drained();
    endtask

    // Degree count: minimum, clamping below and above, upper value bits
    // that must be dropped, and a write to an address with no register.
    task automatic test_degree_counts;
        write_reg(ADDR_NUM_DEGREES, PDATA_W'(RUN_MIN));
        send_point(32'shF000_0000, ALPHA_W'(3));
        send_point(32'sh0000_8000, ALPHA_W'(12));
        wait_drained();
        write_reg(ADDR_NUM_DEGREES, PDATA_W'(0));
        send_point(32'sh1234_5678, ALPHA_W'(2));
        wait_drained();
        write_reg(ADDR_NUM_DEGREES, PDATA_W'(1));
        send_point(32'shFEDC_BA98, ALPHA_W'(9));
        wait_drained();
        write_reg(ADDR_NUM_DEGREES, PDATA_W'(31));
        send_point(32'sh8000_0000, ALPHA_W'(14));
        wait_drained();
        write_reg(ADDR_NUM_DEGREES, PDATA_W'(17));
        send_point(32'sh0C00_0000, ALPHA_W'(4));
        wait_drained();
        write_reg(ADDR_NUM_DEGREES, 32'hFFFF_FFE3);
        send_point(32'sh0080_0000, ALPHA_W'(6));
        wait_drained();
        write_reg(ADDR_UNMAPPED, PDATA_W'(RUN_CAP));
        send_point(32'shFF80_0000, ALPHA_W'(8));
        wait_drained();
        write_reg(ADDR_NUM_DEGREES, PDATA_W'(RUN_CAP));
        send_point(32'sh5555_5555, ALPHA_W'(11));
        wait_drained();
    endtask

    // Random points in segments, each segment under a fresh degree count;
    // idling on most segments, none in the final stretch.
    task automatic test_random_points;
        int sent;
        int seg;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained();
            seg = $urandom_range(8, 30);
            if (sent < RANDOM_ITEMS - CALM_ITEMS) begin
                idle_on = ($urandom_range(0, 3) != 0);
                if (seg > RANDOM_ITEMS - CALM_ITEMS - sent)
                    seg = RANDOM_ITEMS - CALM_ITEMS - sent;
            end else begin
                idle_on = 1'b0;
            end
            write_reg(ADDR_NUM_DEGREES, gen_degree_word());
            for (int i = 0; i < seg && sent < RANDOM_ITEMS; i++) begin
                send_point(gen_point(), ALPHA_W'($urandom_range(0, 15)));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        // Hold every input at a known value; hold reset, then release it.
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_z_value     = '0;
        s_alpha_order = '0;
        m_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        ndeg_cfg      = NUM_DEGREES_RST;
        idle_on       = 1'b0;
        stall_left    = 0;
        quiet_cycles  = 0;
        err_count     = 0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_extremes();
        test_degree_counts();
        test_random_points();

        // Drain, then give any stray result time to show up.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// File: laguerre_poly_recurrence.f
rtl/core/lpr_pkg.sv
rtl/core/lpr_coef_unit.sv
rtl/core/lpr_mac_cell.sv
rtl/core/laguerre_poly_recurrence.sv
bench/tb_top.sv
